@@ hw/rtl/dsm_pkg.sv @@
// Package for the vector distance block: widths, codes, FSM state type and
// the control structs shared between the sequencer and its arithmetic units.
// No dependencies.
package dsm_pkg;

  localparam int MAX_DIM = 1024;
  localparam int CNT_W   = $clog2(MAX_DIM + 1);

  localparam int ELEM_W = 16;
  localparam int OP_W   = ELEM_W + 1;
  localparam int PROD_W = 2 * OP_W;

  // Accumulators are sized for vectors of up to 4096 elements
  localparam int DOT_W  = 44;
  localparam int NORM_W = 43;
  localparam int DIFF_W = 45;
  localparam int DIST_W = 43;

  localparam int ALU_W    = 2 * NORM_W;
  localparam int ROOT_W   = ALU_W / 2;
  localparam int REM_W    = ROOT_W + 3;
  localparam int FRAC_COS = 30;
  localparam int QUO_W    = FRAC_COS + 1;
  localparam int ITER_W   = $clog2(ROOT_W);
  localparam int STEP_W   = 3;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  localparam logic [STEP_W-1:0] STEP_FIN = 3'd5;

  localparam logic [1:0] MET_EUCLID = 2'd0;
  localparam logic [1:0] MET_DOT    = 2'd1;
  localparam logic [1:0] MET_COS    = 2'd2;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_MISMATCH = 2'd1;
  localparam logic [1:0] STAT_TOO_LONG = 2'd2;

  localparam logic REG_METRIC = 1'b0;

  localparam logic [DIST_W-1:0] ONE_Q30 = DIST_W'(1) << FRAC_COS;
  localparam logic [QUO_W-1:0]  QUO_ONE = QUO_W'(1) << FRAC_COS;

  localparam logic signed [DIST_W+1:0] SAT_HI = (DIST_W + 2)'((64'sd1 <<< (DIST_W - 1)) - 1);
  localparam logic signed [DIST_W+1:0] SAT_LO = -(DIST_W + 2)'(64'sd1 <<< (DIST_W - 1));

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_PMUL,
    S_SQRT,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic sub;
  } alu_ctrl_t;

  typedef struct packed {
    logic ge;
  } alu_flag_t;

endpackage

@@ hw/rtl/dsm_mul.sv @@
// Shared signed 17x17 multiplier with registered product.
// Depends on dsm_pkg.
module dsm_mul import dsm_pkg::*; (
  input  logic                     clk,
  input  logic signed [OP_W-1:0]   op_x,
  input  logic signed [OP_W-1:0]   op_y,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_x * op_y;
  end

  assign prod = prod_r;

endmodule

@@ hw/rtl/dsm_alu.sv @@
// Shared wide add/subtract unit: accumulation, shift-add multiply, root and
// divide steps all run through it. Depends on dsm_pkg.
module dsm_alu import dsm_pkg::*; (
  input  alu_ctrl_t          ctrl,
  input  logic [ALU_W-1:0]   opa,
  input  logic [ALU_W-1:0]   opb,
  output logic [ALU_W-1:0]   res,
  output alu_flag_t          flag
);

  logic [ALU_W:0] sum;

  // carry out of a subtract means opa >= opb
  assign sum = {1'b0, opa} + {1'b0, (ctrl.sub ? ~opb : opb)}
             + {{ALU_W{1'b0}}, ctrl.sub};

  assign res     = sum[ALU_W-1:0];
  assign flag.ge = sum[ALU_W];

endmodule

@@ hw/rtl/vector_distance_metrics.sv @@
// Vector distance block. Element pairs stream in; when both last flags are
// set, one distance comes out under the metric register. An element pair
// is accepted in S_IDLE; then in S_MAC one shared multiplier forms the four
// products in turn and the shared adder folds each into its accumulator,
// and no new pair is taken until that ends. At a vector's end the inner
// product adds nothing, Euclidean adds 43 root steps, and cosine 43
// shift-add multiply steps, 43 root steps and 31 divide steps, all on the
// shared adder (a zero norm skips them); then S_EMIT loads the output
// register, waiting while out_stall holds back the previous word. Errors
// (mismatched last flags, vector too long) go straight to S_EMIT.
module vector_distance_metrics import dsm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ELEM_W-1:0] in_elem_a,
  input  logic signed [ELEM_W-1:0] in_elem_b,
  input  logic                     in_last_a,
  input  logic                     in_last_b,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DIST_W-1:0] out_distance,
  output logic [1:0]               out_status,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready
);

  state_t state_r, state_nxt;

  logic [1:0]               metric_r;
  logic [STEP_W-1:0]        step_r, step_nxt;
  logic [ITER_W-1:0]        it_r, it_nxt;
  logic signed [ELEM_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic                     last_r, last_nxt;
  logic [DOT_W-1:0]         dot_r, dot_nxt;
  logic [NORM_W-1:0]        na_r, na_nxt, nb_r, nb_nxt;
  logic [DIFF_W-1:0]        df_r, df_nxt;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [ALU_W-1:0]         sq_r, sq_nxt;
  logic [ROOT_W-1:0]        root_r, root_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  logic [QUO_W-1:0]         quo_r, quo_nxt;
  logic [DIST_W-1:0]        res_dist_r, res_dist_nxt;
  logic [1:0]               res_stat_r, res_stat_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]        out_dist_r, out_dist_nxt;
  logic [1:0]               out_stat_r, out_stat_nxt;

  logic                     in_acc;
  logic                     too_long;
  logic                     mismatch;
  logic                     out_free;
  logic signed [OP_W-1:0]   mul_x, mul_y, diff_ab;
  logic signed [PROD_W-1:0] prod;
  alu_ctrl_t                alu_ctrl;
  alu_flag_t                alu_flag;
  logic [ALU_W-1:0]         alu_a, alu_b, alu_res;
  logic [DOT_W-1:0]         mag;
  logic                     dot_neg;
  logic signed [DIST_W+1:0] neg_dot;
  logic [REM_W-1:0]         rem_sh_sq, rem_sh_dv, trial;
  logic [QUO_W-1:0]         quo_cl;
  logic [ALU_W-1:0]         prod_ext;

  dsm_mul u_mul (
    .clk  (clk),
    .op_x (mul_x),
    .op_y (mul_y),
    .prod (prod)
  );

  dsm_alu u_alu (
    .ctrl (alu_ctrl),
    .opa  (alu_a),
    .opb  (alu_b),
    .res  (alu_res),
    .flag (alu_flag)
  );

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_METRIC) ? {{(DATA_W-2){1'b0}}, metric_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_r <= MET_EUCLID;
    end else if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == REG_METRIC) begin
      metric_r <= pwdata[1:0];
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign too_long = (cnt_r >= CNT_W'(MAX_DIM));
  assign mismatch = (in_last_a != in_last_b);
  assign out_free = !out_valid_r || !out_stall;

  assign diff_ab  = OP_W'(a_r) - OP_W'(b_r);
  assign dot_neg  = dot_r[DOT_W-1];
  assign mag      = dot_neg ? (DOT_W'(0) - dot_r) : dot_r;
  assign neg_dot  = -$signed({{2{dot_r[DOT_W-1]}}, dot_r[DIST_W-1:0]});
  assign prod_ext = {{(ALU_W-PROD_W){prod[PROD_W-1]}}, prod};

  assign rem_sh_sq = {rem_r[REM_W-3:0], sq_r[ALU_W-1 -: 2]};
  assign trial     = {1'b0, root_r, 2'b01};
  assign rem_sh_dv = {rem_r[REM_W-2:0], (it_r == ITER_W'(QUO_W - 1)) ? mag[0] : 1'b0};

  // multiplier operand select
  always_comb begin
    case (step_r)
      3'd1:    begin mul_x = OP_W'(a_r); mul_y = OP_W'(a_r); end
      3'd2:    begin mul_x = OP_W'(b_r); mul_y = OP_W'(b_r); end
      3'd3:    begin mul_x = diff_ab;    mul_y = diff_ab;    end
      default: begin mul_x = OP_W'(a_r); mul_y = OP_W'(b_r); end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (too_long || mismatch) ? S_EMIT : S_MAC;
        end
      end
      S_MAC: begin
        if (step_r == STEP_FIN) begin
          if (!last_r) begin
            state_nxt = S_IDLE;
          end else if (metric_r == MET_DOT) begin
            state_nxt = S_EMIT;
          end else if (metric_r == MET_COS) begin
            state_nxt = (na_r == '0 || nb_r == '0) ? S_EMIT : S_PMUL;
          end else begin
            state_nxt = S_SQRT;
          end
        end
      end
      S_PMUL: begin
        if (it_r == '0) state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (it_r == '0) begin
          state_nxt = (metric_r == MET_COS && root_nxt != '0) ? S_DIV : S_EMIT;
        end
      end
      S_DIV: begin
        if (it_r == '0) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    step_nxt     = step_r;
    it_nxt       = it_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    last_nxt     = last_r;
    dot_nxt      = dot_r;
    na_nxt       = na_r;
    nb_nxt       = nb_r;
    df_nxt       = df_r;
    cnt_nxt      = cnt_r;
    sq_nxt       = sq_r;
    root_nxt     = root_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    res_dist_nxt = res_dist_r;
    res_stat_nxt = res_stat_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_dist_nxt = out_dist_r;
    out_stat_nxt = out_stat_r;
    alu_ctrl.sub = 1'b0;
    alu_a        = '0;
    alu_b        = '0;
    quo_cl       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          a_nxt    = in_elem_a;
          b_nxt    = in_elem_b;
          last_nxt = in_last_a;
          step_nxt = '0;
          res_dist_nxt = '0;
          res_stat_nxt = too_long ? STAT_TOO_LONG : STAT_MISMATCH;
        end
      end
      S_MAC: begin
        step_nxt = step_r + STEP_W'(1);
        alu_b    = prod_ext;
        // fold the product from the previous step
        case (step_r)
          3'd1: begin
            alu_a   = {{(ALU_W-DOT_W){dot_r[DOT_W-1]}}, dot_r};
            dot_nxt = alu_res[DOT_W-1:0];
          end
          3'd2: begin
            alu_a  = ALU_W'(na_r);
            na_nxt = alu_res[NORM_W-1:0];
          end
          3'd3: begin
            alu_a  = ALU_W'(nb_r);
            nb_nxt = alu_res[NORM_W-1:0];
          end
          3'd4: begin
            alu_a  = ALU_W'(df_r);
            df_nxt = alu_res[DIFF_W-1:0];
          end
          default: begin
            alu_a = '0;
          end
        endcase
        if (step_r == STEP_FIN) begin
          cnt_nxt      = cnt_r + CNT_W'(1);
          res_stat_nxt = STAT_OK;
          if (metric_r == MET_DOT) begin
            if (neg_dot > SAT_HI) begin
              res_dist_nxt = SAT_HI[DIST_W-1:0];
            end else if (neg_dot < SAT_LO) begin
              res_dist_nxt = SAT_LO[DIST_W-1:0];
            end else begin
              res_dist_nxt = neg_dot[DIST_W-1:0];
            end
          end else if (metric_r == MET_COS) begin
            res_dist_nxt = ONE_Q30;
            sq_nxt       = '0;
            it_nxt       = ITER_W'(NORM_W - 1);
          end else begin
            sq_nxt   = ALU_W'(df_r);
            root_nxt = '0;
            rem_nxt  = '0;
            it_nxt   = ITER_W'(ROOT_W - 1);
          end
        end
      end
      S_PMUL: begin
        alu_a  = {sq_r[ALU_W-2:0], 1'b0};
        alu_b  = nb_r[it_r] ? ALU_W'(na_r) : '0;
        sq_nxt = alu_res;
        it_nxt = it_r - ITER_W'(1);
        if (it_r == '0) begin
          root_nxt = '0;
          rem_nxt  = '0;
          it_nxt   = ITER_W'(ROOT_W - 1);
        end
      end
      S_SQRT: begin
        alu_ctrl.sub = 1'b1;
        alu_a  = ALU_W'(rem_sh_sq);
        alu_b  = ALU_W'(trial);
        sq_nxt = {sq_r[ALU_W-3:0], 2'b00};
        it_nxt = it_r - ITER_W'(1);
        if (alu_flag.ge) begin
          rem_nxt  = alu_res[REM_W-1:0];
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_sh_sq;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        if (it_r == '0) begin
          if (metric_r == MET_COS) begin
            // root_nxt is the denominator
            rem_nxt = REM_W'(mag >> 1);
            quo_nxt = '0;
            it_nxt  = ITER_W'(QUO_W - 1);
          end else begin
            res_dist_nxt = DIST_W'(root_nxt);
          end
        end
      end
      S_DIV: begin
        alu_ctrl.sub = 1'b1;
        alu_a   = ALU_W'(rem_sh_dv);
        alu_b   = ALU_W'(root_r);
        rem_nxt = alu_flag.ge ? alu_res[REM_W-1:0] : rem_sh_dv;
        quo_nxt = {quo_r[QUO_W-2:0], alu_flag.ge};
        it_nxt  = it_r - ITER_W'(1);
        quo_cl  = (quo_nxt > QUO_ONE) ? QUO_ONE : quo_nxt;
        if (it_r == '0) begin
          res_dist_nxt = dot_neg ? (ONE_Q30 + DIST_W'(quo_cl)) : (ONE_Q30 - DIST_W'(quo_cl));
        end
      end
      S_EMIT: begin
        // accumulators are done with; clear for the next vectors
        dot_nxt = '0;
        na_nxt  = '0;
        nb_nxt  = '0;
        df_nxt  = '0;
        cnt_nxt = '0;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = res_dist_r;
          out_stat_nxt  = res_stat_r;
        end
      end
      default: begin
        step_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      it_r        <= '0;
      dot_r       <= '0;
      na_r        <= '0;
      nb_r        <= '0;
      df_r        <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      it_r        <= it_nxt;
      dot_r       <= dot_nxt;
      na_r        <= na_nxt;
      nb_r        <= nb_nxt;
      df_r        <= df_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    last_r     <= last_nxt;
    sq_r       <= sq_nxt;
    root_r     <= root_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    res_dist_r <= res_dist_nxt;
    res_stat_r <= res_stat_nxt;
    out_dist_r <= out_dist_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;
  assign out_status   = out_stat_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_DIM))
    else $error("element count above limit");

  a_mismatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && mismatch && !too_long) |=>
      (state_r == S_EMIT && res_stat_r == STAT_MISMATCH))
    else $error("mismatched last flags not flagged");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STAT_OK) |-> (out_distance == '0))
    else $error("error word with nonzero distance");

endmodule

@@ verif/tb_vector_distance_metrics.sv @@
// Self-checking testbench for vector_distance_metrics: streams element pairs
// under every metric, predicts each distance and status, and checks them.
// Depends on dsm_pkg and the vector_distance_metrics RTL.
`timescale 1ns / 100ps

module tb_vector_distance_metrics;
  import dsm_pkg::*;

  typedef struct packed {
    logic signed [ELEM_W-1:0] a;
    logic signed [ELEM_W-1:0] b;
    logic                     la;
    logic                     lb;
  } pair_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [1:0]        status;
  } dist_word_t;

  localparam int CYCLE_LIMIT = 2_000_000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [ELEM_W-1:0] in_elem_a = '0;
  logic signed [ELEM_W-1:0] in_elem_b = '0;
  logic in_last_a = 1'b0;
  logic in_last_b = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [DIST_W-1:0] out_distance;
  logic [1:0] out_status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  pair_t      pending_pairs[$];
  dist_word_t expected_dists[$];
  int         errors = 0;
  int         cycle = 0;
  int         hold_left = 0;
  bit         hold_done = 0;

  // predictor state
  logic [1:0]         pred_metric = MET_EUCLID;
  logic signed [47:0] dot_sum = '0;
  logic [47:0]        norm_a_sum = '0;
  logic [47:0]        norm_b_sum = '0;
  logic [47:0]        diff_sq_sum = '0;
  int                 elem_cnt = 0;

  vector_distance_metrics dut (.*);

  always #1 clk = ~clk;

  function automatic logic [63:0] floor_sqrt(input logic [127:0] x);
    logic [63:0]  r;
    logic [63:0]  c;
    logic [127:0] sq;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      sq = {64'd0, c} * {64'd0, c};
      if (sq <= x) r = c;
    end
    return r;
  endfunction

  function automatic logic signed [63:0] cosine_dist();
    logic [127:0] prod;
    logic [127:0] quo;
    logic [63:0]  den;
    logic [63:0]  mag;
    if (norm_a_sum == 0 || norm_b_sum == 0) return 64'sd1 << FRAC_COS;
    prod = {80'd0, norm_a_sum} * {80'd0, norm_b_sum};
    den = floor_sqrt(prod);
    if (den == 0) return 64'sd1 << FRAC_COS;
    mag = (dot_sum < 0) ? 64'(-dot_sum) : 64'(dot_sum);
    quo = ({64'd0, mag} << FRAC_COS) / {64'd0, den};
    if (quo > (128'd1 << FRAC_COS)) quo = 128'd1 << FRAC_COS;
    if (dot_sum < 0) return (64'sd1 << FRAC_COS) + $signed(quo[63:0]);
    return (64'sd1 << FRAC_COS) - $signed(quo[63:0]);
  endfunction

  function automatic void clear_sums();
    dot_sum = '0;
    norm_a_sum = '0;
    norm_b_sum = '0;
    diff_sq_sum = '0;
    elem_cnt = 0;
  endfunction

  function automatic void predict_distance(input pair_t p);
    logic signed [47:0] a;
    logic signed [47:0] b;
    logic signed [63:0] d;
    dist_word_t w;
    a = p.a;
    b = p.b;
    if (elem_cnt >= MAX_DIM) begin
      clear_sums();
      w.distance = '0;
      w.status = STAT_TOO_LONG;
      expected_dists.push_back(w);
      return;
    end
    if (p.la != p.lb) begin
      clear_sums();
      w.distance = '0;
      w.status = STAT_MISMATCH;
      expected_dists.push_back(w);
      return;
    end
    dot_sum += a * b;
    norm_a_sum += 48'(a * a);
    norm_b_sum += 48'(b * b);
    diff_sq_sum += 48'((a - b) * (a - b));
    elem_cnt++;
    if (!p.la) return;
    case (pred_metric)
      MET_DOT: begin
        d = -64'(dot_sum);
        if (d > (64'sd1 <<< (DIST_W - 1)) - 1) d = (64'sd1 <<< (DIST_W - 1)) - 1;
        if (d < -(64'sd1 <<< (DIST_W - 1))) d = -(64'sd1 <<< (DIST_W - 1));
      end
      MET_COS: d = cosine_dist();
      default: d = $signed(floor_sqrt({80'd0, diff_sq_sum}));
    endcase
    clear_sums();
    w.distance = d[DIST_W-1:0];
    w.status = STAT_OK;
    expected_dists.push_back(w);
  endfunction

  // cycle count and timeout
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("vector_distance_metrics verification failed");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    pair_t nxt;
    bit    busy;
    bit    idle;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid && in_stall;
      if (in_valid && !in_stall) predict_distance({in_elem_a, in_elem_b, in_last_a, in_last_b});
      if (!busy) begin
        idle = (cycle < 6000 || cycle >= 10000) && ($urandom_range(0, 99) < 20);
        if (!idle && pending_pairs.size() > 0) begin
          nxt = pending_pairs.pop_front();
          in_elem_a <= nxt.a;
          in_elem_b <= nxt.b;
          in_last_a <= nxt.la;
          in_last_b <= nxt.lb;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off once results are flowing
  always @(posedge clk) begin
    if (!hold_done && cycle > 3000 && expected_dists.size() > 0 &&
        pending_pairs.size() > 20) begin
      hold_done <= 1'b1;
      hold_left <= 2000;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (cycle >= 6000 && cycle < 10000) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 20);
    end
  end

  // monitor
  always @(posedge clk) begin
    dist_word_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_dists.size() == 0) begin
        $error("unexpected word: distance %0d status %0d", out_distance, out_status);
        errors++;
      end else begin
        w = expected_dists.pop_front();
        if (out_distance !== w.distance) begin
          $error("distance: expected %0d actual %0d", $signed(w.distance), out_distance);
          errors++;
        end
        if (out_status !== w.status) begin
          $error("status: expected %0d actual %0d", w.status, out_status);
          errors++;
        end
      end
    end
  end

  task automatic write_metric(input logic [1:0] m);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(REG_METRIC) << 2;
    pwdata <= DATA_W'(m);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pred_metric = m;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic push(input int a, input int b, input bit la, input bit lb);
    pair_t p;
    p.a = ELEM_W'(a);
    p.b = ELEM_W'(b);
    p.la = la;
    p.lb = lb;
    pending_pairs.push_back(p);
  endtask

  function automatic int rand_elem();
    case ($urandom_range(0, 9))
      0: return -32768;
      1: return 32767;
      2: return 0;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // random vectors, now and then broken by a mismatched flag pair
  task automatic push_random(input int n_items);
    int cnt;
    int len;
    cnt = 0;
    while (cnt < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 64) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 99) == 0) begin
          if ($urandom_range(0, 1)) push(rand_elem(), rand_elem(), 1'b1, 1'b0);
          else push(rand_elem(), rand_elem(), 1'b0, 1'b1);
        end else begin
          push(rand_elem(), rand_elem(), i == len - 1, i == len - 1);
        end
        cnt++;
      end
    end
  endtask

  // hold the sender until every word has come back and the block is quiet
  task automatic drain();
    wait (pending_pairs.size() == 0 && !in_valid && expected_dists.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // euclidean: extremes, single elements, mismatches both ways
    write_metric(MET_EUCLID);
    push(32767, -32768, 1'b0, 1'b0);
    push(-32768, 32767, 1'b1, 1'b1);
    push(-32768, -32768, 1'b1, 1'b1);
    push(5, 7, 1'b1, 1'b0);
    push(5, 7, 1'b0, 1'b1);
    push(1, 0, 1'b1, 1'b1);
    push_random(100);
    drain();

    // negated inner product, plus one vector that runs past MAX_DIM
    write_metric(MET_DOT);
    push(-32768, -32768, 1'b1, 1'b1);
    push(32767, -32768, 1'b1, 1'b1);
    push(0, 0, 1'b1, 1'b1);
    for (int i = 0; i <= MAX_DIM; i++) push(rand_elem(), rand_elem(), 1'b0, 1'b0);
    push(3, 4, 1'b1, 1'b1);
    push_random(100);
    drain();

    // cosine: zero norms, parallel and opposite vectors
    write_metric(MET_COS);
    push(0, 5, 1'b1, 1'b1);
    push(5, 0, 1'b1, 1'b1);
    push(0, 0, 1'b1, 1'b1);
    push(1000, 1000, 1'b0, 1'b0);
    push(-300, -300, 1'b1, 1'b1);
    push(32767, -32767, 1'b1, 1'b1);
    push(-32768, -32768, 1'b0, 1'b0);
    push(32767, 32767, 1'b1, 1'b1);
    push(1, 2, 1'b1, 1'b1);
    push_random(120);
    drain();

    // unused metric code falls back to euclidean
    write_metric(2'd3);
    push(100, -100, 1'b1, 1'b1);
    push_random(60);
    drain();

    write_metric(MET_DOT);
    push_random(50);
    drain();

    write_metric(MET_COS);
    push_random(70);
    drain();

    if (errors == 0) begin
      $display("vector_distance_metrics verification clean");
    end else begin
      $display("vector_distance_metrics verification failed");
    end
    $finish;
  end

endmodule
